### sv/iiwm_pkg.sv
package iiwm_pkg;

  localparam int ELEM_W       = 16;  // signed element
  localparam int SUM_W        = 36;  // signed prefix sums
  localparam int IDX_W        = 10;  // row and column fields of a result
  localparam int SIDE_W       = 11;  // matrix_side register
  localparam int MAX_SIDE_DEF = 1024;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 11'd1024;

  // APB map: one 32-bit register
  localparam int APB_AW = 2;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-1:0] ADDR_MATRIX_SIDE = 2'd0;

endpackage

### sv/iiwm_if.sv
interface iiwm_elem_if;
  logic                                valid;
  logic                                ready;
  logic signed [iiwm_pkg::ELEM_W-1:0]  element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

interface iiwm_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [iiwm_pkg::SUM_W-1:0]  prefix_sum;
  logic        [iiwm_pkg::IDX_W-1:0]  row_index;
  logic        [iiwm_pkg::IDX_W-1:0]  col_index;
  logic                               is_last;
  logic signed [iiwm_pkg::SUM_W-1:0]  best_sum;
  logic        [iiwm_pkg::IDX_W-1:0]  best_row;
  logic        [iiwm_pkg::IDX_W-1:0]  best_col;

  modport source (output valid, output prefix_sum, output row_index, output col_index,
                  output is_last, output best_sum, output best_row, output best_col,
                  input ready);
  modport sink   (input valid, input prefix_sum, input row_index, input col_index,
                  input is_last, input best_sum, input best_row, input best_col,
                  output ready);
endinterface

### sv/iiwm_ram.sv
module iiwm_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/iiwm_cfg.sv
module iiwm_cfg #(
  parameter int MAX_SIDE = iiwm_pkg::MAX_SIDE_DEF,
  localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [iiwm_pkg::APB_AW-1:0] paddr,
  input  logic [iiwm_pkg::APB_DW-1:0] pwdata,
  output logic [iiwm_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output logic [CW-1:0]               side_last
);

  localparam logic [CW-1:0] MAX_LAST = CW'(MAX_SIDE - 1);

  logic [iiwm_pkg::SIDE_W-1:0] matrix_side;
  logic [iiwm_pkg::SIDE_W-1:0] side_dec;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_side <= iiwm_pkg::SIDE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == iiwm_pkg::ADDR_MATRIX_SIDE) begin
      matrix_side <= pwdata[iiwm_pkg::SIDE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == iiwm_pkg::ADDR_MATRIX_SIDE) begin
      prdata = iiwm_pkg::APB_DW'(matrix_side);
    end
  end

  // Zero acts as one, anything past the line store acts as its depth
  assign side_dec = matrix_side - 1'b1;

  always_comb begin
    priority if (matrix_side == '0) begin
      side_last = '0;
    end else if (32'(matrix_side) > MAX_SIDE) begin
      side_last = MAX_LAST;
    end else begin
      side_last = CW'(side_dec);
    end
  end

endmodule

### sv/integral_image_with_max.sv
// Channel   Dir  Payload                                            Handshake
// elem_ch   in   element_value                                      valid/ready
// res_ch    out  prefix_sum, row_index, col_index, is_last,         valid/ready
//                best_sum, best_row, best_col
// APB       in   matrix_side at byte address 0                      psel/penable, pready=1
//
// One element per cycle while res_ch does not stall; the add stage register
// feeds the result register (line-store read, then add, compare and write back).
// The single line store does one read and one write per cycle, which sets the rate.
// Reset clears counters, running row sum and best tracking; the line store is
// not cleared, since every entry is written in row 0 before its read is used.
// A stall on res_ch holds the output register, then the add stage, then elem_ch.
module integral_image_with_max #(
  parameter int MAX_SIDE = iiwm_pkg::MAX_SIDE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [iiwm_pkg::APB_AW-1:0] paddr,
  input  logic [iiwm_pkg::APB_DW-1:0] pwdata,
  output logic [iiwm_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  iiwm_elem_if.sink                   elem_ch,
  iiwm_res_if.source                  res_ch
);

  localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SUM_W = iiwm_pkg::SUM_W;
  localparam int ELEM_W = iiwm_pkg::ELEM_W;
  localparam int IDX_W = iiwm_pkg::IDX_W;

  logic [CW-1:0] side_last;

  iiwm_cfg #(.MAX_SIDE(MAX_SIDE)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .side_last (side_last)
  );

  // ---------------------------------------------------------------- handshake
  logic in_fire;
  logic s1_valid;
  logic s1_adv;     // add stage may move into the output register
  logic s1_fire;

  assign s1_adv         = !res_ch.valid || res_ch.ready;
  assign s1_fire        = s1_valid && s1_adv;
  assign elem_ch.ready  = !s1_valid || s1_adv;
  assign in_fire        = elem_ch.valid && elem_ch.ready;

  // ---------------------------------------------------------------- stage 0
  // Position counters and running row sum; issue the line-store read.
  logic [CW-1:0]    row_cnt, col_cnt;
  logic [CW-1:0]    row_c, col_c;
  logic [SUM_W-1:0] rrs;
  logic [SUM_W-1:0] rrs_next;
  logic [SUM_W-1:0] elem_ext;
  logic             last_col, last_row;

  // Clamp counters into the current side in case it shrank between matrices
  assign col_c    = (col_cnt > side_last) ? side_last : col_cnt;
  assign row_c    = (row_cnt > side_last) ? side_last : row_cnt;
  assign last_col = (col_c == side_last);
  assign last_row = (row_c == side_last);
  assign elem_ext = {{(SUM_W-ELEM_W){elem_ch.element_value[ELEM_W-1]}},
                     elem_ch.element_value};
  // Restart the row sum at column zero
  assign rrs_next = ((col_c == '0) ? '0 : rrs) + elem_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
      rrs     <= '0;
    end else if (in_fire) begin
      rrs <= rrs_next;
      if (last_col) begin
        col_cnt <= '0;
        row_cnt <= last_row ? '0 : row_c + 1'b1;
      end else begin
        col_cnt <= col_c + 1'b1;
        row_cnt <= row_c;
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic [SUM_W-1:0] s1_rrs;
  logic [CW-1:0]    s1_row, s1_col;
  logic             s1_row_nz, s1_first, s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_rrs    <= rrs_next;
      s1_row    <= row_c;
      s1_col    <= col_c;
      s1_row_nz <= (row_c != '0);
      s1_first  <= (row_c == '0) && (col_c == '0);
      s1_last   <= last_col && last_row;
    end
  end

  // Line store: read at stage 0, write back the finished sum at stage 1.
  // Read and write never meet on the same column in the same cycle for an
  // item that uses the read: the column repeats only a full row later.
  logic [SUM_W-1:0] above;
  logic [SUM_W-1:0] s1_sum;

  iiwm_ram #(.WIDTH(SUM_W), .DEPTH(MAX_SIDE)) u_line (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col),
    .wdata (s1_sum),
    .re    (in_fire),
    .raddr (col_c),
    .rdata (above)
  );

  // Top row takes no contribution from above
  assign s1_sum = s1_rrs + (s1_row_nz ? above : '0);

  logic [SUM_W-1:0] best_val;
  logic [CW-1:0]    best_r, best_c;
  logic             take;

  // Strictly greater keeps the earliest position on a tie
  assign take = s1_first || ($signed(s1_sum) > $signed(best_val));

  always_ff @(posedge clk) begin
    if (rst) begin
      best_val <= '0;
      best_r   <= '0;
      best_c   <= '0;
    end else if (s1_fire && take) begin
      best_val <= s1_sum;
      best_r   <= s1_row;
      best_c   <= s1_col;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      res_ch.valid <= 1'b0;
    end else if (s1_fire) begin
      res_ch.valid <= 1'b1;
    end else if (res_ch.ready) begin
      res_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_ch.prefix_sum <= s1_sum;
      res_ch.row_index  <= IDX_W'(s1_row);
      res_ch.col_index  <= IDX_W'(s1_col);
      res_ch.is_last    <= s1_last;
      res_ch.best_sum   <= take ? s1_sum : best_val;
      res_ch.best_row   <= IDX_W'(take ? s1_row : best_r);
      res_ch.best_col   <= IDX_W'(take ? s1_col : best_c);
    end
  end

  // ---------------------------------------------------------------- checks
  a_best_dominates: assert property (@(posedge clk) disable iff (rst)
    res_ch.valid |-> $signed(res_ch.best_sum) >= $signed(res_ch.prefix_sum))
    else $error("best_sum below prefix_sum of the same result");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !elem_ch.ready |-> s1_valid && res_ch.valid && !res_ch.ready)
    else $error("input held off without a downstream stall");

  a_line_no_clash: assert property (@(posedge clk) disable iff (rst)
    in_fire && s1_fire && (row_c != '0) |-> col_c != s1_col)
    else $error("line-store read meets write on the same column");

endmodule

### tb/tb_integral_image_with_max.sv
`timescale 1ns / 1ps

module tb_integral_image_with_max;

  localparam int LINE_DEPTH   = iiwm_pkg::MAX_SIDE_DEF;
  localparam int RANDOM_ITEMS = 1100;
  localparam int ELEM_W       = iiwm_pkg::ELEM_W;
  localparam int SUM_W        = iiwm_pkg::SUM_W;
  localparam int IDX_W        = iiwm_pkg::IDX_W;
  localparam int SIDE_W       = iiwm_pkg::SIDE_W;
  localparam int APB_AW       = iiwm_pkg::APB_AW;
  localparam int APB_DW       = iiwm_pkg::APB_DW;

  localparam logic signed [ELEM_W-1:0] ELEM_MAX   = 16'sh7FFF;
  localparam logic signed [ELEM_W-1:0] ELEM_MIN   = 16'sh8000;
  localparam logic        [SIDE_W-1:0] SIDE_FIELD = '1;

  // Content styles for the random part; tiny values breed ties in the best search
  typedef enum int {FILL_ANY, FILL_TINY, FILL_EXTREME, FILL_RISING} fill_kind_t;
  // Receiver stall patterns, cycled through on a fixed period
  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_BURSTY, SINK_ALTERNATE} sink_mode_t;

  typedef struct {
    logic signed [SUM_W-1:0] prefix_sum;
    logic        [IDX_W-1:0] row_index;
    logic        [IDX_W-1:0] col_index;
    logic                    is_last;
    logic signed [SUM_W-1:0] best_sum;
    logic        [IDX_W-1:0] best_row;
    logic        [IDX_W-1:0] best_col;
  } sat_result_t;

  // Summed-area predictor with running maximum, plus the queue of awaited results
  class integral_scoreboard;
    logic signed [SUM_W-1:0] line_sums [LINE_DEPTH];
    bit                      line_written [LINE_DEPTH];
    logic signed [SUM_W-1:0] row_sum;
    int unsigned             row_pos;
    int unsigned             col_pos;
    logic signed [SUM_W-1:0] top_sum;
    int unsigned             top_row;
    int unsigned             top_col;
    logic        [SIDE_W-1:0] side_reg;
    sat_result_t             awaited [$];
    int unsigned             mismatches;
    int unsigned             matrices_done;

    function new();
      foreach (line_sums[i]) begin
        line_sums[i]    = '0;
        line_written[i] = 1'b0;
      end
      row_sum       = '0;
      row_pos       = 0;
      col_pos       = 0;
      top_sum       = '0;
      top_row       = 0;
      top_col       = 0;
      side_reg      = iiwm_pkg::SIDE_RESET;
      mismatches    = 0;
      matrices_done = 0;
    endfunction

    // A side of zero behaves as one, anything past the line store as its depth
    function int unsigned span(logic [SIDE_W-1:0] s);
      if (s == 0) return 1;
      if (s > LINE_DEPTH) return LINE_DEPTH;
      return s;
    endfunction

    function void set_side(logic [SIDE_W-1:0] s);
      side_reg = s;
    endfunction

    function bit at_matrix_start();
      return row_pos == 0 && col_pos == 0;
    endfunction

    // Number of leading line-store columns that hold a written value
    function int unsigned written_run();
      int unsigned n;
      n = 0;
      while (n < LINE_DEPTH && line_written[n]) n++;
      return n;
    endfunction

    // Growing the side below the top row must never reach an unwritten column
    function bit side_is_safe(logic [SIDE_W-1:0] s);
      if (row_pos == 0) return 1'b1;
      return span(s) <= written_run();
    endfunction

    function void complain(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] %s", $time, what);
    endfunction

    function void note_element(logic signed [ELEM_W-1:0] e);
      int unsigned             last;
      int unsigned             r;
      int unsigned             c;
      logic signed [SUM_W-1:0] wide;
      logic signed [SUM_W-1:0] total;
      sat_result_t             want;
      last = span(side_reg) - 1;
      r    = (row_pos > last) ? last : row_pos;
      c    = (col_pos > last) ? last : col_pos;
      wide = e;
      if (c == 0) row_sum = '0;
      row_sum = row_sum + wide;
      total   = row_sum;
      if (r != 0) total = total + line_sums[c];
      line_sums[c]    = total;
      line_written[c] = 1'b1;
      if ((r == 0 && c == 0) || total > top_sum) begin
        top_sum = total;
        top_row = r;
        top_col = c;
      end
      want.prefix_sum = total;
      want.row_index  = IDX_W'(r);
      want.col_index  = IDX_W'(c);
      want.is_last    = (c >= last) && (r >= last);
      want.best_sum   = top_sum;
      want.best_row   = IDX_W'(top_row);
      want.best_col   = IDX_W'(top_col);
      awaited.push_back(want);
      if (c >= last) begin
        col_pos = 0;
        row_pos = (r >= last) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
        row_pos = r;
      end
    endfunction

    function void check_result(sat_result_t got);
      sat_result_t want;
      string       at;
      if (awaited.size() == 0) begin
        complain($sformatf("result with nothing awaited: sum %0d at (%0d,%0d)",
                           got.prefix_sum, got.row_index, got.col_index));
        return;
      end
      want = awaited.pop_front();
      at   = $sformatf("(%0d,%0d)", want.row_index, want.col_index);
      if (want.is_last) matrices_done++;
      if (got.prefix_sum !== want.prefix_sum)
        complain($sformatf("prefix_sum at %s: expected %0d, got %0d",
                           at, want.prefix_sum, got.prefix_sum));
      if (got.row_index !== want.row_index)
        complain($sformatf("row_index at %s: expected %0d, got %0d",
                           at, want.row_index, got.row_index));
      if (got.col_index !== want.col_index)
        complain($sformatf("col_index at %s: expected %0d, got %0d",
                           at, want.col_index, got.col_index));
      if (got.is_last !== want.is_last)
        complain($sformatf("is_last at %s: expected %0b, got %0b",
                           at, want.is_last, got.is_last));
      if (got.best_sum !== want.best_sum)
        complain($sformatf("best_sum at %s: expected %0d, got %0d",
                           at, want.best_sum, got.best_sum));
      if (got.best_row !== want.best_row)
        complain($sformatf("best_row at %s: expected %0d, got %0d",
                           at, want.best_row, got.best_row));
      if (got.best_col !== want.best_col)
        complain($sformatf("best_col at %s: expected %0d, got %0d",
                           at, want.best_col, got.best_col));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  iiwm_elem_if elem_ch ();
  iiwm_res_if  res_ch ();

  integral_scoreboard sb = new();

  // Sender pacing and run statistics
  int unsigned burst_left   = 0;
  bit          gaps_off     = 1'b0;
  int unsigned items_sent   = 0;
  int unsigned side_writes  = 0;
  int unsigned midway       = 0;

  // Receiver pattern state
  int unsigned sink_cycle   = 0;
  int unsigned sink_hold    = 0;
  bit          sink_level   = 1'b0;

  integral_image_with_max u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .elem_ch (elem_ch),
    .res_ch  (res_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: rotate in turn through open, random, bursty and alternating stall
  // patterns, so stalls land on every stage of the pipeline.
  always @(posedge clk) begin
    sink_cycle++;
    case (sink_mode_t'((sink_cycle / 300) % 4))
      SINK_OPEN: begin
        res_ch.ready <= 1'b1;
      end
      SINK_RANDOM: begin
        res_ch.ready <= ($urandom_range(0, 3) != 0);
      end
      SINK_BURSTY: begin
        if (sink_hold == 0) begin
          sink_level = !sink_level;
          sink_hold  = sink_level ? $urandom_range(1, 10) : $urandom_range(1, 8);
        end
        sink_hold--;
        res_ch.ready <= sink_level;
      end
      default: begin
        res_ch.ready <= sink_cycle[0];
      end
    endcase
  end

  // Watch both channels at the same edge. Check the outgoing result before
  // noting the new request: a request can never produce its result at the
  // edge that takes it, so this order keeps the queue consistent.
  always @(posedge clk) begin : watch
    sat_result_t got;
    if (!rst) begin
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        got.prefix_sum = res_ch.prefix_sum;
        got.row_index  = res_ch.row_index;
        got.col_index  = res_ch.col_index;
        got.is_last    = res_ch.is_last;
        got.best_sum   = res_ch.best_sum;
        got.best_row   = res_ch.best_row;
        got.best_col   = res_ch.best_col;
        sb.check_result(got);
      end
      if (elem_ch.valid === 1'b1 && elem_ch.ready === 1'b1)
        sb.note_element(elem_ch.element_value);
    end
  end

  // Offer one request and hold it until taken. Bursts of random length are
  // separated by random gaps; valid stays high across a burst.
  task automatic push_element(input logic signed [ELEM_W-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = gaps_off ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        elem_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    elem_ch.valid         <= 1'b1;
    elem_ch.element_value <= v;
    do @(posedge clk); while (elem_ch.ready !== 1'b1);
    burst_left--;
    items_sent++;
  endtask

  // Drop valid and hold off until every awaited result is back, then let the
  // two-stage pipeline settle.
  task automatic drain();
    elem_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.awaited.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Setup then access phase; the register takes the value at the access edge
  task automatic apb_write(input logic [SIDE_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= iiwm_pkg::ADDR_MATRIX_SIDE;
    pwdata  <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_side(value);
    side_writes++;
  endtask

  // Read the side register back and compare it with the predicted copy
  task automatic apb_confirm_side();
    logic [APB_DW-1:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= iiwm_pkg::ADDR_MATRIX_SIDE;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== APB_DW'(sb.side_reg))
      sb.complain($sformatf("matrix_side read back: expected %0d, got %0d",
                            sb.side_reg, got));
  endtask

  // Change the side only once the block is idle; count changes that land
  // part-way through a matrix, where the counters get clamped.
  task automatic change_side(input logic [SIDE_W-1:0] value);
    drain();
    if (!sb.at_matrix_start()) midway++;
    apb_write(value);
    apb_confirm_side();
  endtask

  function automatic logic signed [ELEM_W-1:0] element_for(fill_kind_t fill);
    case (fill)
      FILL_TINY:    return ELEM_W'(int'($urandom_range(0, 4)) - 2);
      FILL_EXTREME: return $urandom_range(0, 1) ? ELEM_MAX : ELEM_MIN;
      FILL_RISING:  return ELEM_W'($urandom_range(0, 64));
      default:      return ELEM_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [SIDE_W-1:0] side_pick;
    int unsigned       pick;
    int unsigned       count;
    int unsigned       goal;
    fill_kind_t        fill;

    rst                   <= 1'b1;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    elem_ch.valid         <= 1'b0;
    elem_ch.element_value <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset value of the side register
    apb_confirm_side();

    // Smallest side: every request is a whole matrix and its own best
    change_side(SIDE_W'(1));
    push_element(ELEM_MAX);
    push_element(ELEM_MIN);
    push_element(ELEM_W'(0));

    // 2x2 at the field extremes, then all zeros so every later sum ties
    // and the best must stay at the origin
    change_side(SIDE_W'(2));
    repeat (4) push_element(ELEM_MAX);
    repeat (4) push_element(ELEM_MIN);
    repeat (4) push_element(ELEM_W'(0));

    // Zero side behaves as one
    change_side(SIDE_W'(0));
    push_element(ELEM_W'(5));
    push_element(ELEM_W'(-5));

    // Field all ones clamps to the line-store depth; start the top row,
    // then shrink part-way so the column counter wraps early and the next
    // row reads the line store
    change_side(SIDE_FIELD);
    push_element(ELEM_W'(100));
    push_element(ELEM_W'(-7));
    push_element(ELEM_MAX);
    change_side(SIDE_W'(3));
    push_element(ELEM_W'(-1));
    push_element(ELEM_W'(2));
    push_element(ELEM_MIN);

    // Random phases: new side (or just a pause), then whole matrices or a
    // partial run with one content style and one pacing style
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 19);
      case (pick)
        0:       side_pick = SIDE_FIELD;
        1:       side_pick = '0;
        2:       side_pick = SIDE_W'(LINE_DEPTH);
        3:       side_pick = SIDE_W'(1);
        4, 5, 6: side_pick = SIDE_W'($urandom_range(13, 40));
        default: side_pick = SIDE_W'($urandom_range(2, 12));
      endcase
      if (!sb.side_is_safe(side_pick))
        side_pick = SIDE_W'($urandom_range(1, sb.written_run()));
      if ($urandom_range(0, 3) == 0)
        drain();
      else
        change_side(side_pick);

      if (sb.at_matrix_start() && sb.span(sb.side_reg) <= 12 && $urandom_range(0, 2) != 0)
        count = sb.span(sb.side_reg) * sb.span(sb.side_reg) * $urandom_range(1, 3);
      else
        count = $urandom_range(1, 40);
      fill     = fill_kind_t'($urandom_range(0, 3));
      gaps_off = ($urandom_range(0, 4) == 0);
      repeat (count) push_element(element_for(fill));
    end

    gaps_off = 1'b0;
    drain();
    repeat (6) @(posedge clk);

    $display("Covered %0d element requests, %0d complete matrices, %0d side writes",
             items_sent, sb.matrices_done, side_writes);
    $display("(%0d of them part-way through a matrix), %0d mismatches",
             midway, sb.mismatches);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("Run timed out with %0d results still awaited", sb.awaited.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
